// ----- rtl/deq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg
// Types, request and status codes, and sizing constants for the deque unit.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int OCC_W  = 5;

  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_PEEK_FRONT = 3'd4;
  localparam logic [2:0] REQ_PEEK_BACK  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]               req_type;
    logic signed [WORD_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_value;
    logic [1:0]               status;
    logic [OCC_W-1:0]         occupancy;
  } rsp_t;

  typedef enum logic {
    S_IDLE,
    S_BUSY
  } state_t;

  // (base + offset) modulo DEPTH, for offset <= DEPTH
  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                 input logic [CNT_W-1:0]  offset);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(offset);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return ADDR_W'(sum);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/double_ended_queue_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded deque of signed 32-bit words in a circular single-port RAM.
// ----------------------------------------------------------------------------
// Each request (push, pop or peek at either end) yields one response with the
// word read, a status and the occupancy after the request. In the accept
// cycle the RAM is written or read and the head and count registers are
// updated; once the response register is free, the registered RAM read data
// is loaded into the response register. The unit holds one item in flight and
// accepts no new request before that item is in the response register.
// A new item is accepted while the previous response still waits in the
// response register; that item then holds until the response is taken.
// ----------------------------------------------------------------------------
module double_ended_queue_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire deq_pkg::req_t req_data,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output deq_pkg::rsp_t      rsp_data
);

  deq_pkg::state_t state, state_next;

  logic [deq_pkg::ADDR_W-1:0] head, head_next;
  logic [deq_pkg::CNT_W-1:0]  count, count_next;

  logic                       pend_use_rd;
  logic [1:0]                 pend_status;
  logic [deq_pkg::OCC_W-1:0]  pend_occ;

  logic                       acc;
  logic                       load_rsp;
  logic                       use_rd;
  logic [1:0]                 status;
  logic                       ram_we;
  logic                       ram_re;
  logic [deq_pkg::ADDR_W-1:0] ram_addr;
  logic [deq_pkg::WORD_W-1:0] ram_rdata;
  logic                       is_empty;
  logic                       is_full;

  assign acc      = req_valid && req_ready;
  assign is_empty = (count == '0);
  assign is_full  = (count == deq_pkg::CNT_W'(deq_pkg::DEPTH));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      deq_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = deq_pkg::S_BUSY;
        end
      end
      deq_pkg::S_BUSY: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = deq_pkg::S_IDLE;
        end
      end
      default: state_next = deq_pkg::S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    req_ready = 1'b0;
    load_rsp  = 1'b0;
    unique case (state)
      deq_pkg::S_IDLE: req_ready = 1'b1;
      deq_pkg::S_BUSY: load_rsp  = !rsp_valid || rsp_ready;
      default: ;
    endcase
  end

  // request decode and pointer update
  always_comb begin
    head_next  = head;
    count_next = count;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = head;
    use_rd     = 1'b0;
    status     = deq_pkg::ST_OK;
    if (acc) begin
      unique case (req_data.req_type) inside
        deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK: begin
          if (is_full) begin
            status = deq_pkg::ST_FULL;
          end else begin
            ram_we     = 1'b1;
            count_next = count + 1'b1;
            if (req_data.req_type == deq_pkg::REQ_PUSH_FRONT) begin
              head_next = deq_pkg::wrap_add(head, deq_pkg::CNT_W'(deq_pkg::DEPTH - 1));
              ram_addr  = head_next;
            end else begin
              ram_addr = deq_pkg::wrap_add(head, count);
            end
          end
        end
        deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_POP_BACK,
        deq_pkg::REQ_PEEK_FRONT, deq_pkg::REQ_PEEK_BACK: begin
          if (is_empty) begin
            status = deq_pkg::ST_EMPTY;
          end else begin
            ram_re = 1'b1;
            use_rd = 1'b1;
            if (req_data.req_type == deq_pkg::REQ_POP_FRONT ||
                req_data.req_type == deq_pkg::REQ_PEEK_FRONT) begin
              ram_addr = head;
            end else begin
              ram_addr = deq_pkg::wrap_add(head, count - 1'b1);
            end
            if (req_data.req_type == deq_pkg::REQ_POP_FRONT) begin
              head_next  = deq_pkg::wrap_add(head, deq_pkg::CNT_W'(1));
              count_next = count - 1'b1;
            end else if (req_data.req_type == deq_pkg::REQ_POP_BACK) begin
              count_next = count - 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  deq_ram #(
    .WIDTH(deq_pkg::WORD_W),
    .DEPTH(deq_pkg::DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(req_data.push_value),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= deq_pkg::S_IDLE;
      head      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pend_use_rd <= use_rd;
      pend_status <= status;
      pend_occ    <= deq_pkg::OCC_W'(count_next);
    end
    if (load_rsp) begin
      rsp_data.read_value <= pend_use_rd ? ram_rdata : '0;
      rsp_data.status     <= pend_status;
      rsp_data.occupancy  <= pend_occ;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
    else $error("occupancy beyond capacity");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("store read and write in one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    acc |=> (state == deq_pkg::S_BUSY))
    else $error("accepted item not in flight");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (acc && is_full && (req_data.req_type == deq_pkg::REQ_PUSH_FRONT ||
                        req_data.req_type == deq_pkg::REQ_PUSH_BACK))
    |=> (count == $past(count) && head == $past(head)))
    else $error("push on full deque changed state");

  a_rsp_load: assert property (@(posedge clk) disable iff (rst)
    load_rsp |=> rsp_valid)
    else $error("response not presented");

endmodule
`default_nettype wire

// ----- rtl/deq_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic                                       re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                           wdata,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for double_ended_queue_unit. A shadow deque predicts
// the response of every accepted request. The bench runs directed cases for
// the empty and full corners, then random push/pop/peek traffic under random
// input gaps and output stalls. It also runs one long output hold-off that
// backs the unit up into its input.
// ----------------------------------------------------------------------------
module testbench;
  import deq_pkg::*;

  localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
  localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

  localparam int FLOW_ANY      = 0;
  localparam int FLOW_FRONT_IN = 1;
  localparam int FLOW_BACK_IN  = 2;

  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_data = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp_data;

  // shadow deque
  logic signed [WORD_W-1:0] shadow_words [DEPTH];
  int unsigned front_slot = 0;
  int unsigned words_held = 0;

  rsp_t pending_responses [$];
  rsp_t due_rsp;
  int   errors = 0;

  // sender pacing
  bit gaps_enabled = 1'b1;
  int burst_left = 0;

  // receiver pacing
  int holdoff_ask = 0;
  int holdoff_left = 0;
  int stall_mode = 0;
  int mode_timer = 32;
  int pattern_phase = 0;
  logic [7:0] stall_pattern = 8'b1011_0010;

  double_ended_queue_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic rsp_t predict_deque_result(input req_t item);
    rsp_t        result;
    int unsigned slot;
    result.read_value = '0;
    result.status     = ST_OK;
    case (item.req_type)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (words_held >= DEPTH) begin
          result.status = ST_FULL;
        end else begin
          if (item.req_type == REQ_PUSH_FRONT) begin
            front_slot = (front_slot + DEPTH - 1) % DEPTH;
            slot = front_slot;
          end else begin
            slot = (front_slot + words_held) % DEPTH;
          end
          shadow_words[slot] = item.push_value;
          words_held++;
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK, REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
        if (words_held == 0) begin
          result.status = ST_EMPTY;
        end else begin
          if (item.req_type == REQ_POP_FRONT || item.req_type == REQ_PEEK_FRONT) begin
            slot = front_slot;
          end else begin
            slot = (front_slot + words_held - 1) % DEPTH;
          end
          result.read_value = shadow_words[slot];
          if (item.req_type == REQ_POP_FRONT) begin
            front_slot = (front_slot + 1) % DEPTH;
            words_held--;
          end else if (item.req_type == REQ_POP_BACK) begin
            words_held--;
          end
        end
      end
      default: ;
    endcase
    result.occupancy = OCC_W'(words_held);
    return result;
  endfunction

  function automatic req_t make_req(input logic [2:0] code,
                                    input logic signed [WORD_W-1:0] value);
    req_t item;
    item.req_type   = code;
    item.push_value = value;
    return item;
  endfunction

  function automatic logic signed [WORD_W-1:0] random_word();
    case ($urandom_range(15))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t random_request(input int push_pct, input int pop_pct,
                                          input int noise_pct, input int flow);
    int         pick;
    bit         at_back;
    logic [2:0] code;
    pick    = $urandom_range(99);
    at_back = $urandom_range(1);
    if (flow == FLOW_FRONT_IN) begin
      at_back = (pick < push_pct) ? 1'b0 : 1'b1;
    end else if (flow == FLOW_BACK_IN) begin
      at_back = (pick < push_pct) ? 1'b1 : 1'b0;
    end
    if (pick < push_pct) begin
      code = at_back ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
    end else if (pick < push_pct + pop_pct) begin
      code = at_back ? REQ_POP_BACK : REQ_POP_FRONT;
    end else if (pick >= 100 - noise_pct) begin
      code = at_back ? REQ_UNUSED_7 : REQ_UNUSED_6;
    end else begin
      code = at_back ? REQ_PEEK_BACK : REQ_PEEK_FRONT;
    end
    return make_req(code, random_word());
  endfunction

  // Offers one item and returns right after the edge that accepts it.
  task automatic send_item(input req_t item);
    int gap;
    if (gaps_enabled && burst_left == 0) begin
      req_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    req_valid <= 1'b1;
    req_data  <= item;
    do @(posedge clk); while (!req_ready);
    pending_responses.push_back(predict_deque_result(item));
  endtask

  task automatic wait_for_drain();
    req_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_random(input int count, input int push_pct, input int pop_pct,
                             input int noise_pct, input int flow);
    repeat (count) send_item(random_request(push_pct, pop_pct, noise_pct, flow));
  endtask

  task automatic test_empty_deque();
    send_item(make_req(REQ_POP_FRONT, WORD_MAX));
    send_item(make_req(REQ_POP_BACK, WORD_MIN));
    send_item(make_req(REQ_PEEK_FRONT, -1));
    send_item(make_req(REQ_PEEK_BACK, '0));
    send_item(make_req(REQ_UNUSED_6, WORD_MAX));
    send_item(make_req(REQ_UNUSED_7, WORD_MIN));
    wait_for_drain();
  endtask

  task automatic test_fill_to_full();
    logic signed [WORD_W-1:0] fill_words [16] = '{
      32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'shFFFF_FFFF,
      32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_0001, 32'sh8000_0001,
      32'sh7FFF_FFFE, 32'sh0F0F_0F0F, 32'shF0F0_F0F0, 32'sh3333_3333,
      32'shCCCC_CCCC, 32'sh00FF_00FF, 32'shFF00_FF00, 32'sh1234_5678
    };
    for (int i = 0; i < DEPTH; i++) begin
      send_item(make_req(i[0] ? REQ_PUSH_BACK : REQ_PUSH_FRONT, fill_words[i % 16]));
    end
    send_item(make_req(REQ_PUSH_FRONT, WORD_MIN));
    send_item(make_req(REQ_PUSH_BACK, WORD_MAX));
    send_item(make_req(REQ_PEEK_FRONT, '0));
    send_item(make_req(REQ_PEEK_BACK, '0));
    wait_for_drain();
  endtask

  task automatic test_backpressure();
    wait_for_drain();
    gaps_enabled = 1'b0;
    holdoff_ask  = 300;
    send_random(32, 55, 25, 5, FLOW_ANY);
    wait_for_drain();
    gaps_enabled = 1'b1;
  endtask

  task automatic test_random_mix();
    send_random(450, 35, 30, 5, FLOW_ANY);
    wait_for_drain();
  endtask

  task automatic test_fill_heavy();
    send_random(300, 60, 20, 4, FLOW_ANY);
  endtask

  task automatic test_drain_heavy();
    gaps_enabled = 1'b0;
    send_random(250, 20, 60, 4, FLOW_ANY);
    gaps_enabled = 1'b1;
  endtask

  task automatic test_wraparound();
    send_random(150, 45, 40, 3, FLOW_FRONT_IN);
    gaps_enabled = 1'b0;
    send_random(150, 45, 40, 3, FLOW_BACK_IN);
    gaps_enabled = 1'b1;
  endtask

  // receiver: rotating stall modes plus an on-demand long hold-off
  always @(posedge clk) begin
    if (holdoff_ask != 0) begin
      holdoff_left = holdoff_ask;
      holdoff_ask  = 0;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      rsp_ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: rsp_ready <= 1'b1;
        1: rsp_ready <= $urandom_range(1);
        2: rsp_ready <= ($urandom_range(3) == 0);
        default: rsp_ready <= stall_pattern[pattern_phase % 8];
      endcase
      pattern_phase++;
      mode_timer--;
      if (mode_timer == 0) begin
        stall_mode = $urandom_range(3);
        mode_timer = $urandom_range(16, 96);
      end
    end
  end

  task automatic report_field(input string field, input longint expected,
                              input longint actual);
    if (expected != actual) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, field, expected, actual);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_responses.size() == 0) begin
        errors++;
        $display("%0t: response with nothing pending: expected none actual %p",
                 $time, rsp_data);
      end else begin
        due_rsp = pending_responses.pop_front();
        report_field("read_value", due_rsp.read_value, rsp_data.read_value);
        report_field("status", due_rsp.status, rsp_data.status);
        report_field("occupancy", due_rsp.occupancy, rsp_data.occupancy);
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_deque();
    test_fill_to_full();
    test_backpressure();
    test_random_mix();
    test_fill_heavy();
    test_drain_heavy();
    test_wraparound();
    wait_for_drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #(4_000_000);
    $display("testbench: errors");
    $finish;
  end

endmodule
